// File: src/lj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_pkg
// Shared widths, register indexes, reset values and the controller to
// datapath command bundle for the LCG jump-ahead block.
// ----------------------------------------------------------------------------
package lj_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BIT_CNT_W = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] MULT_RESET = 32'h0003_43FD;
  localparam logic [WORD_W-1:0] INC_RESET  = 32'h0026_9EC3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC  = 8'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new item and seed the accumulators
    logic step;   // fold in one bit of the step count
    logic fin;    // apply the accumulated map to the seed
  } lj_cmd_t;

endpackage

// File: src/lj_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_cfg
// Configuration register file: LCG multiplier and increment.
// ----------------------------------------------------------------------------
module lj_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [lj_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lj_pkg::WORD_W-1:0]     wr_data,
  output logic [lj_pkg::WORD_W-1:0]     mult,
  output logic [lj_pkg::WORD_W-1:0]     inc
);
  import lj_pkg::*;

  logic [WORD_W-1:0] mult_r;
  logic [WORD_W-1:0] inc_r;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULT_RESET;
      inc_r  <= INC_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_MULT) begin
        mult_r <= wr_data;
      end else if (wr_index == REG_INC) begin
        inc_r <= wr_data;
      end
    end
  end

  assign mult = mult_r;
  assign inc  = inc_r;

endmodule

// File: src/lj_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_ctrl
// Controller: sequences load, one step per step-count bit, and finish.
// ----------------------------------------------------------------------------
module lj_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output lj_pkg::lj_cmd_t cmd
);
  import lj_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [BIT_CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and bit counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_STEP;
          cnt_nxt   = '0;
        end
      end
      ST_STEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(WORD_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.step = (state_r == ST_STEP);
  assign cmd.fin  = (state_r == ST_FIN);

endmodule

// File: src/lj_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_dpath
// Datapath: square-and-accumulate of the affine step map, one bit per step,
// then the final seed * A + C and the result register.
// ----------------------------------------------------------------------------
module lj_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lj_pkg::lj_cmd_t           cmd,
  input  logic [lj_pkg::WORD_W-1:0] mult,
  input  logic [lj_pkg::WORD_W-1:0] inc,
  input  logic [lj_pkg::WORD_W-1:0] seed_in,
  input  logic [lj_pkg::WORD_W-1:0] step_count,
  output logic                      res_valid,
  output logic [lj_pkg::WORD_W-1:0] res_seed
);
  import lj_pkg::*;

  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] n_r;
  logic [WORD_W-1:0] acc_m_r;
  logic [WORD_W-1:0] acc_c_r;
  logic [WORD_W-1:0] cur_m_r;
  logic [WORD_W-1:0] cur_c_r;
  logic [WORD_W-1:0] res_r;
  logic              res_valid_r;

  logic [WORD_W-1:0] acc_m_mul;
  logic [WORD_W-1:0] acc_c_mul;
  logic [WORD_W-1:0] cur_m_sq;
  logic [WORD_W-1:0] cur_c_mul;
  logic [WORD_W-1:0] cur_m_p1;
  logic [WORD_W-1:0] fin_val;

  // Compose the accumulated map with the current power, and square the power
  assign acc_m_mul = acc_m_r * cur_m_r;
  assign acc_c_mul = (acc_c_r * cur_m_r) + cur_c_r;
  assign cur_m_p1  = cur_m_r + WORD_W'(1);
  assign cur_c_mul = cur_m_p1 * cur_c_r;
  assign cur_m_sq  = cur_m_r * cur_m_r;
  assign fin_val   = (acc_m_r * seed_r) + acc_c_r;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seed_r  <= seed_in;
      n_r     <= step_count;
      acc_m_r <= WORD_W'(1);
      acc_c_r <= '0;
      cur_m_r <= mult;
      cur_c_r <= inc;
    end else if (cmd.step) begin
      if (n_r[0]) begin
        acc_m_r <= acc_m_mul;
        acc_c_r <= acc_c_mul;
      end
      cur_m_r <= cur_m_sq;
      cur_c_r <= cur_c_mul;
      n_r     <= n_r >> 1;
    end
    if (cmd.fin) begin
      res_r <= fin_val;
    end
  end

  // Result strobe: raised in the cycle after finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= cmd.fin;
    end
  end

  assign res_valid = res_valid_r;
  assign res_seed  = res_r;

endmodule

// File: src/lcg_jump_ahead.sv
`timescale 1ns / 1ps
// One item at a time: start is ignored while busy. The loop over the 32 step-count
//   bits runs one bit per cycle through the square-and-accumulate multipliers.
// A new item may be accepted at the same edge that takes the previous result.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// Reset (synchronous, active low) idles the block and restores default registers.
// ----------------------------------------------------------------------------
// lcg_jump_ahead
// Advances a 32-bit LCG state by an arbitrary step count using repeated
// squaring of the step map.
// ----------------------------------------------------------------------------
module lcg_jump_ahead (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [lj_pkg::WORD_W-1:0]    in_seed_in,
  input  logic [lj_pkg::WORD_W-1:0]    in_step_count,
  output logic                         out_valid,
  output logic [lj_pkg::WORD_W-1:0]    out_seed_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lj_pkg::WORD_W-1:0]    cfg_data
);
  import lj_pkg::*;

  lj_cmd_t           cmd;
  logic [WORD_W-1:0] mult;
  logic [WORD_W-1:0] inc;

  // Take configuration beats while idle and no item is being started
  assign cfg_ready = !busy && !start;

  lj_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .mult     (mult),
    .inc      (inc)
  );

  lj_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lj_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .mult       (mult),
    .inc        (inc),
    .seed_in    (in_seed_in),
    .step_count (in_step_count),
    .res_valid  (out_valid),
    .res_seed   (out_seed_out)
  );

endmodule

// File: src/lj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_checker
// Port-level checks on the command handshake and result strobe timing.
// ----------------------------------------------------------------------------
module lj_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted beat makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted start did not raise busy");

  // The result strobe lasts one cycle
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // A result follows only the end of a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("out_valid without a finished item");

  // Every finished item produces a result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("item finished without a result");

endmodule

bind lcg_jump_ahead lj_checker u_lj_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
